// ----- rtl/core/icv_pkg.sv -----
// Shared types, character codes and the precedence function for the
// infix to postfix converter. No dependencies.
package icv_pkg;

   localparam int STACK_DEPTH_DEFAULT = 32;
   localparam int QUEUE_DEPTH         = 4;
   localparam int QUEUE_PTR_W         = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_CARET  = 8'h5E;

   typedef enum logic [2:0] {
      KIND_OPERAND,
      KIND_OPEN,
      KIND_CLOSE,
      KIND_OPER,
      KIND_END
   } item_kind_type;

   // one classified word, front to back
   typedef struct packed {
      item_kind_type kind;
      logic [1:0]    prec;
      logic [7:0]    char_code;
   } cls_word_type;

   typedef struct packed {
      logic         valid;
      cls_word_type word;
   } qlink_type;

   function automatic logic [1:0] prec_of(input logic [7:0] c);
      logic [1:0] p;
      p = 2'd0;
      if (c == CHAR_CARET) begin
         p = 2'd3;
      end else if (c == CHAR_STAR || c == CHAR_SLASH) begin
         p = 2'd2;
      end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
         p = 2'd1;
      end
      return p;
   endfunction

endpackage

// ----- rtl/core/icv_front.sv -----
// Input side: classifies each incoming character and holds it in a short
// queue for the stack engine. Uses icv_pkg.
module icv_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [7:0]           req_char_code,
   input  logic                 req_end_of_expr,
   output icv_pkg::qlink_type   q_link,
   input  logic                 q_pop
);

   localparam int PW = icv_pkg::QUEUE_PTR_W;
   localparam int CW = $clog2(icv_pkg::QUEUE_DEPTH + 1);

   icv_pkg::cls_word_type q_mem_ff [icv_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] q_count_ff, q_count_in;

   icv_pkg::cls_word_type cls_word;
   logic                  accept;
   logic                  take;
   logic                  is_alnum;

   always_comb begin
      is_alnum = (req_char_code >= 8'h30 && req_char_code <= 8'h39) ||
                 (req_char_code >= 8'h41 && req_char_code <= 8'h5A) ||
                 (req_char_code >= 8'h61 && req_char_code <= 8'h7A);
      cls_word.char_code = req_char_code;
      cls_word.prec      = icv_pkg::prec_of(req_char_code);
      priority if (req_end_of_expr) begin
         cls_word.kind = icv_pkg::KIND_END;
      end else if (is_alnum) begin
         cls_word.kind = icv_pkg::KIND_OPERAND;
      end else if (req_char_code == icv_pkg::CHAR_LPAREN) begin
         cls_word.kind = icv_pkg::KIND_OPEN;
      end else if (req_char_code == icv_pkg::CHAR_RPAREN) begin
         cls_word.kind = icv_pkg::KIND_CLOSE;
      end else begin
         cls_word.kind = icv_pkg::KIND_OPER;
      end
   end

   assign req_full     = (q_count_ff == CW'(icv_pkg::QUEUE_DEPTH));
   assign accept       = req_push && !req_full;
   assign take         = q_pop && q_link.valid;
   assign q_link.valid = (q_count_ff != '0);
   assign q_link.word  = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in  = accept ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in  = take ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      q_count_in = q_count_ff + CW'(accept) - CW'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         q_count_ff <= '0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         q_count_ff <= q_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_mem_ff[wr_ptr_ff] <= cls_word;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      q_count_ff <= CW'(icv_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (q_count_ff == '0 || q_count_ff == CW'(icv_pkg::QUEUE_DEPTH))
      |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (accept && !take) |=> q_count_ff == $past(q_count_ff) + CW'(1))
      else $error("queue count missed a write");

endmodule

// ----- rtl/core/icv_back.sv -----
// Stack engine: runs the operator stack for each classified word and
// drives the result register. Uses icv_pkg.
module icv_back #(
   parameter int STACK_DEPTH = icv_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  icv_pkg::qlink_type q_link,
   output logic               q_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [7:0]         rsp_out_char,
   output logic               rsp_last_of_run,
   output logic               rsp_expr_done,
   output logic               rsp_overflow_seen
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CLOSE = 4'b0010,
      ST_OPER  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [7:0]    stack_mem [STACK_DEPTH];
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [7:0]    top_char_ff, top_char_in;
   logic          top_from_mem_ff, top_from_mem_in;
   logic [7:0]    rd_data_ff;

   logic [7:0]    cur_char_ff, cur_char_in;
   logic [1:0]    cur_prec_ff, cur_prec_in;
   logic          pend_valid_ff, pend_valid_in;
   logic [7:0]    pend_char_ff, pend_char_in;

   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_char_ff, out_char_in;
   logic          out_last_ff, out_last_in;
   logic          out_done_ff, out_done_in;
   logic          out_ovf_ff, out_ovf_in;

   logic [7:0]    top_val;
   logic          out_free;
   logic          out_load;
   logic          push_en;
   logic [7:0]    push_char;
   logic          pop_en;
   logic          ovf_clear;
   logic          cont;
   logic          stack_full;
   logic [CW-1:0] rd_idx;

   assign top_val    = top_from_mem_ff ? rd_data_ff : top_char_ff;
   assign out_free   = !out_valid_ff || rsp_pop;
   assign stack_full = (count_ff == CW'(STACK_DEPTH));
   assign rd_idx     = count_ff - CW'(2);

   always_comb begin
      state_in      = state_ff;
      q_pop         = 1'b0;
      push_en       = 1'b0;
      push_char     = cur_char_ff;
      pop_en        = 1'b0;
      ovf_clear     = 1'b0;
      cur_char_in   = cur_char_ff;
      cur_prec_in   = cur_prec_ff;
      pend_valid_in = pend_valid_ff;
      pend_char_in  = pend_char_ff;
      out_load      = 1'b0;
      out_char_in   = out_char_ff;
      out_last_in   = out_last_ff;
      out_done_in   = out_done_ff;
      out_ovf_in    = out_ovf_ff;
      cont          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_link.valid) begin
               cur_char_in = q_link.word.char_code;
               cur_prec_in = q_link.word.prec;
               unique case (q_link.word.kind)
                  icv_pkg::KIND_OPERAND: begin
                     if (out_free) begin
                        q_pop       = 1'b1;
                        out_load    = 1'b1;
                        out_char_in = q_link.word.char_code;
                        out_last_in = 1'b1;
                        out_done_in = 1'b0;
                        out_ovf_in  = 1'b0;
                     end
                  end
                  icv_pkg::KIND_OPEN: begin
                     q_pop     = 1'b1;
                     push_en   = 1'b1;
                     push_char = q_link.word.char_code;
                  end
                  icv_pkg::KIND_CLOSE: begin
                     q_pop    = 1'b1;
                     state_in = ST_CLOSE;
                  end
                  icv_pkg::KIND_OPER: begin
                     q_pop    = 1'b1;
                     state_in = ST_OPER;
                  end
                  icv_pkg::KIND_END: begin
                     q_pop    = 1'b1;
                     state_in = ST_FLUSH;
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_CLOSE, ST_OPER: begin
            // a popped char waits in pend until we know whether it ends the run
            if (state_ff == ST_CLOSE) begin
               cont = (count_ff != '0) && (top_val != icv_pkg::CHAR_LPAREN);
            end else begin
               cont = (count_ff != '0) && (cur_prec_ff <= icv_pkg::prec_of(top_val));
            end
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  out_load    = 1'b1;
                  out_char_in = pend_char_ff;
                  out_last_in = !cont;
                  out_done_in = 1'b0;
                  out_ovf_in  = 1'b0;
               end
               if (cont) begin
                  pop_en        = 1'b1;
                  pend_valid_in = 1'b1;
                  pend_char_in  = top_val;
               end else begin
                  pend_valid_in = 1'b0;
                  state_in      = ST_IDLE;
                  if (state_ff == ST_CLOSE) begin
                     pop_en = (count_ff != '0);  // drop the matching open paren
                  end else begin
                     push_en = 1'b1;
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               out_load = 1'b1;
               if (count_ff != '0) begin
                  pop_en      = 1'b1;
                  out_char_in = top_val;
                  out_last_in = 1'b0;
                  out_done_in = 1'b0;
                  out_ovf_in  = 1'b0;
               end else begin
                  out_char_in = '0;
                  out_last_in = 1'b1;
                  out_done_in = 1'b1;
                  out_ovf_in  = ovf_ff;
                  ovf_clear   = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      out_valid_in = out_load || (out_valid_ff && !rsp_pop);
   end

   always_comb begin
      count_in        = count_ff;
      ovf_in          = ovf_ff && !ovf_clear;
      top_char_in     = top_char_ff;
      top_from_mem_in = top_from_mem_ff;
      if (push_en) begin
         if (stack_full) begin
            ovf_in = 1'b1;
         end else begin
            count_in        = count_ff + CW'(1);
            top_char_in     = push_char;
            top_from_mem_in = 1'b0;
         end
      end else if (pop_en) begin
         count_in        = count_ff - CW'(1);
         top_from_mem_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         count_ff        <= '0;
         ovf_ff          <= 1'b0;
         top_from_mem_ff <= 1'b0;
         pend_valid_ff   <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         ovf_ff          <= ovf_in;
         top_from_mem_ff <= top_from_mem_in;
         pend_valid_ff   <= pend_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_char_ff  <= top_char_in;
      cur_char_ff  <= cur_char_in;
      cur_prec_ff  <= cur_prec_in;
      pend_char_ff <= pend_char_in;
      out_char_ff  <= out_char_in;
      out_last_ff  <= out_last_in;
      out_done_ff  <= out_done_in;
      out_ovf_ff   <= out_ovf_in;
   end

   // stack storage: a pushed top sits in top_char_ff; a pop fetches the entry below
   always_ff @(posedge clock) begin
      if (push_en && !stack_full) begin
         stack_mem[count_ff[AW-1:0]] <= push_char;
      end
      if (pop_en && count_ff >= CW'(2)) begin
         rd_data_ff <= stack_mem[rd_idx[AW-1:0]];
      end
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_out_char      = out_char_ff;
   assign rsp_last_of_run   = out_last_ff;
   assign rsp_expr_done     = out_done_ff;
   assign rsp_overflow_seen = out_ovf_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_pend_state: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff == ST_CLOSE || state_ff == ST_OPER))
      else $error("pending char outside a pop run");

   a_flush_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && state_in == ST_IDLE) |-> count_ff == '0)
      else $error("end marker with entries left on the stack");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == ST_IDLE)
      else $error("queue popped while busy");

   a_no_push_pop: assert property (@(posedge clock) disable iff (reset)
      !(push_en && pop_en))
      else $error("push and pop in one cycle");

endmodule

// ----- rtl/core/infix_to_postfix_converter.sv -----
// Top level of the shunting-yard infix to postfix converter.
// Instantiates icv_front and icv_back; uses icv_pkg.
//
// Characters enter through a queue port (push/full) and are classified
// into a 4-word queue at up to one per cycle; the stack engine behind it
// takes one word at a time and puts each postfix character into a
// one-word result register read through empty/pop. In the engine an
// operand or '(' is handled in the idle state; a ')' or an operator
// pops entries in its own state and then drops the '(' or is pushed,
// and the end of expression pops every entry and then emits the
// end marker; the stack memory gives one pop a cycle and a stalled
// result register holds the engine. The stack is STACK_DEPTH entries
// of memory, top in a register, and needs no clearing after reset.
module infix_to_postfix_converter #(
   parameter int STACK_DEPTH = icv_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_char_code,
   input  logic       req_end_of_expr,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_of_run,
   output logic       rsp_expr_done,
   output logic       rsp_overflow_seen
);

   icv_pkg::qlink_type q_link;
   logic               q_pop;

   icv_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_char_code   (req_char_code),
      .req_end_of_expr (req_end_of_expr),
      .q_link          (q_link),
      .q_pop           (q_pop)
   );

   icv_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_link            (q_link),
      .q_pop             (q_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_char      (rsp_out_char),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_expr_done     (rsp_expr_done),
      .rsp_overflow_seen (rsp_overflow_seen)
   );

endmodule
